// ===== rtl/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, types and the cosine table for the vector pair angle unit.
// ----------------------------------------------------------------------------
package vpa_pkg;

    // default sample width and reduced component width
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RED_W           = 17;
    localparam int MAG_LIMIT       = 32768;

    // pipeline depths of the iterative sections
    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 31;
    localparam int SR_STEPS = 8;

    // angle range and Q30 unity
    localparam int ANGLE_MAX = 180;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_LEN = 1'b1;

    // one degree in Q40 radians
    localparam logic [63:0] DEG_STEP_Q40 = 64'd19190098069;

    typedef logic signed [31:0] cos_tab_t [0:ANGLE_MAX];

    // cos(k degrees) in Q30 for k in 0..90, eleven-term series in Q31
    function automatic logic signed [31:0] cos_first_quadrant(int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        int unsigned        n;
        if (k >= 90)
        begin
            return 32'sd0;
        end
        x    = (64'(k) * DEG_STEP_Q40 + 64'd256) >> 9;
        x2   = (x * x) >> 31;
        term = 64'd1 << 31;
        sum  = $signed(term);
        for (n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 31) / 64'((2 * n - 1) * (2 * n));
            if (n[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        rnd = (sum + 64'sd1) >>> 1;
        return rnd[31:0];
    endfunction

    // full table for 0..180 degrees, odd symmetry about 90
    function automatic cos_tab_t build_cos_table();
        cos_tab_t    tab;
        int unsigned k;
        for (k = 0; k <= ANGLE_MAX; k++)
        begin
            if (k <= 90)
            begin
                tab[k] = cos_first_quadrant(k);
            end
            else
            begin
                tab[k] = -cos_first_quadrant(ANGLE_MAX - k);
            end
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage

// ===== rtl/vector_pair_angle_unit.sv =====
// ----------------------------------------------------------------------------
// vector_pair_angle_unit
// Angle in whole degrees between a lid and a body acceleration vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (pair_valid / pair_stall) carries one pair of 3-axis
//   samples per transfer. Output channel (angle_valid / angle_stall) returns
//   one angle_degrees / status result per input transfer, in order.
//   One pair is taken every cycle unless a held result stalls the pipeline;
//   the rate is set by the fully pipelined datapath: vector reduction and
//   products (6 stages), a bit-per-stage square root (32 stages), a
//   bit-per-stage divider (31 stages), a clamp stage (1) and a binary
//   search of the cosine table (8 stages).
//   A zero-length vector gives status 1 with angle 0.
//   Reset clears all valid bits; no item is in flight afterwards.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   pair_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector_pair_angle_unit #(
    parameter int SAMPLE_BITS = vpa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_valid,
    output logic                          pair_stall,
    input  logic signed [SAMPLE_BITS-1:0] lid_x,
    input  logic signed [SAMPLE_BITS-1:0] lid_y,
    input  logic signed [SAMPLE_BITS-1:0] lid_z,
    input  logic signed [SAMPLE_BITS-1:0] body_x,
    input  logic signed [SAMPLE_BITS-1:0] body_y,
    input  logic signed [SAMPLE_BITS-1:0] body_z,
    output logic                          angle_valid,
    input  logic                          angle_stall,
    output logic [7:0]                    angle_degrees,
    output logic                          status
);
    import vpa_pkg::*;

    localparam int SH_W   = $clog2(SAMPLE_BITS + 1);
    localparam int PRE_N  = 5;
    localparam int NST    = PRE_N + 1 + SQ_STEPS + DV_STEPS + SR_STEPS + 1;
    localparam int SQ_END = PRE_N + SQ_STEPS;
    localparam int DV_END = SQ_END + DV_STEPS;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        logic [31:0] dmag;
        logic        neg;
        logic        err;
    } sq_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] len;
        logic [30:0] quo;
        logic        neg;
        logic        err;
    } dv_st_t;

    typedef struct packed {
        logic signed [31:0] q;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic               err;
    } sr_st_t;

    logic en;
    logic [NST-1:0] vld_reg;

    logic signed [SAMPLE_BITS-1:0] samp [0:1][0:2];

    logic                   sg1_reg [0:1][0:2];
    logic [SAMPLE_BITS-1:0] mg1_reg [0:1][0:2];
    logic                   sg2_reg [0:1][0:2];
    logic [SAMPLE_BITS-1:0] mg2_reg [0:1][0:2];
    logic [SH_W-1:0]        sh2_reg [0:1];
    logic [SH_W-1:0]        sh2_next [0:1];
    logic signed [RED_W-1:0] rd3_reg [0:1][0:2];
    logic [30:0]            pa4_reg [0:2];
    logic [30:0]            pb4_reg [0:2];
    logic signed [31:0]     pd4_reg [0:2];
    logic [31:0]            sa5_reg;
    logic [31:0]            sb5_reg;
    logic signed [33:0]     dot5_reg;

    sq_st_t sq_reg [0:SQ_STEPS];
    dv_st_t dv_reg [0:DV_STEPS-1];
    sr_st_t sr_reg [0:SR_STEPS];

    // advance everything unless a finished result is held
    assign en         = !(vld_reg[NST-1] && angle_stall);
    assign pair_stall = !en;

    // move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], pair_valid};
        end
    end

    assign samp[0][0] = lid_x;
    assign samp[0][1] = lid_y;
    assign samp[0][2] = lid_z;
    assign samp[1][0] = body_x;
    assign samp[1][1] = body_y;
    assign samp[1][2] = body_z;

    // stage 1: split each component into sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int v = 0; v < 2; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sg1_reg[v][c] <= samp[v][c][SAMPLE_BITS-1];
                    mg1_reg[v][c] <= samp[v][c][SAMPLE_BITS-1] ?
                                     SAMPLE_BITS'(-samp[v][c]) :
                                     SAMPLE_BITS'(samp[v][c]);
                end
            end
        end
    end

    // stage 2: pick the smallest shift that brings the largest magnitude in range
    always_comb
    begin
        logic [SAMPLE_BITS-1:0] mx;
        for (int v = 0; v < 2; v++)
        begin
            mx = mg1_reg[v][0];
            if (mg1_reg[v][1] > mx)
            begin
                mx = mg1_reg[v][1];
            end
            if (mg1_reg[v][2] > mx)
            begin
                mx = mg1_reg[v][2];
            end
            sh2_next[v] = SH_W'(SAMPLE_BITS);
            for (int s = SAMPLE_BITS; s >= 0; s--)
            begin
                if (32'(mx >> s) <= 32'(MAG_LIMIT))
                begin
                    sh2_next[v] = SH_W'(s);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg2_reg <= sg1_reg;
            mg2_reg <= mg1_reg;
            sh2_reg <= sh2_next;
        end
    end

    // stage 3: apply the shift and restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int v = 0; v < 2; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rd3_reg[v][c] <= sg2_reg[v][c] ?
                        -$signed({1'b0, 16'(mg2_reg[v][c] >> sh2_reg[v])}) :
                        $signed({1'b0, 16'(mg2_reg[v][c] >> sh2_reg[v])});
                end
            end
        end
    end

    // stage 4: component products
    always_ff @(posedge clk)
    begin
        logic signed [2*RED_W-1:0] pa;
        logic signed [2*RED_W-1:0] pb;
        logic signed [2*RED_W-1:0] pd;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pa = rd3_reg[0][c] * rd3_reg[0][c];
                pb = rd3_reg[1][c] * rd3_reg[1][c];
                pd = rd3_reg[0][c] * rd3_reg[1][c];
                pa4_reg[c] <= pa[30:0];
                pb4_reg[c] <= pb[30:0];
                pd4_reg[c] <= pd[31:0];
            end
        end
    end

    // stage 5: squared lengths and dot product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa5_reg  <= 32'(pa4_reg[0]) + 32'(pa4_reg[1]) + 32'(pa4_reg[2]);
            sb5_reg  <= 32'(pb4_reg[0]) + 32'(pb4_reg[1]) + 32'(pb4_reg[2]);
            dot5_reg <= 34'(pd4_reg[0]) + 34'(pd4_reg[1]) + 34'(pd4_reg[2]);
        end
    end

    // stage 6: product of squared lengths, flag a zero-length vector
    always_ff @(posedge clk)
    begin
        logic signed [33:0] dneg;
        if (en)
        begin
            dneg            = -dot5_reg;
            sq_reg[0].rem  <= 64'(sa5_reg) * 64'(sb5_reg);
            sq_reg[0].root <= '0;
            sq_reg[0].neg  <= dot5_reg[33];
            sq_reg[0].dmag <= dot5_reg[33] ? dneg[31:0] : dot5_reg[31:0];
            sq_reg[0].err  <= (sa5_reg == '0) || (sb5_reg == '0);
        end
    end

    // square root, one result bit per stage
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        always_ff @(posedge clk)
        begin
            sq_st_t sq_next;
            if (en)
            begin
                sq_next = sq_reg[i];
                if (sq_reg[i].rem >= sq_reg[i].root + BIT)
                begin
                    sq_next.rem  = sq_reg[i].rem - (sq_reg[i].root + BIT);
                    sq_next.root = (sq_reg[i].root >> 1) + BIT;
                end
                else
                begin
                    sq_next.root = sq_reg[i].root >> 1;
                end
                sq_reg[i+1] <= sq_next;
            end
        end
    end

    // first divide step: the integer quotient bit of |dot| / len
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].len <= sq_reg[SQ_STEPS].root[31:0];
            dv_reg[0].neg <= sq_reg[SQ_STEPS].neg;
            dv_reg[0].err <= sq_reg[SQ_STEPS].err;
            if (sq_reg[SQ_STEPS].dmag >= sq_reg[SQ_STEPS].root[31:0])
            begin
                dv_reg[0].rem <= sq_reg[SQ_STEPS].dmag - sq_reg[SQ_STEPS].root[31:0];
                dv_reg[0].quo <= 31'd1;
            end
            else
            begin
                dv_reg[0].rem <= sq_reg[SQ_STEPS].dmag;
                dv_reg[0].quo <= 31'd0;
            end
        end
    end

    // fraction bits of the cosine, one per stage
    for (genvar i = 1; i < DV_STEPS; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [32:0] r2;
            dv_st_t      dv_next;
            if (en)
            begin
                r2      = {dv_reg[i-1].rem, 1'b0};
                dv_next = dv_reg[i-1];
                if (r2 >= 33'(dv_reg[i-1].len))
                begin
                    dv_next.rem = 32'(r2 - 33'(dv_reg[i-1].len));
                    dv_next.quo = {dv_reg[i-1].quo[29:0], 1'b1};
                end
                else
                begin
                    dv_next.rem = r2[31:0];
                    dv_next.quo = {dv_reg[i-1].quo[29:0], 1'b0};
                end
                dv_reg[i] <= dv_next;
            end
        end
    end

    // clamp and sign the cosine, open the search window
    always_ff @(posedge clk)
    begin
        logic signed [31:0] mag;
        if (en)
        begin
            mag = $signed(32'(dv_reg[DV_STEPS-1].quo));
            if (mag > ONE_Q30)
            begin
                mag = ONE_Q30;
            end
            sr_reg[0].q   <= dv_reg[DV_STEPS-1].neg ? -mag : mag;
            sr_reg[0].lo  <= '0;
            sr_reg[0].hi  <= 8'(ANGLE_MAX);
            sr_reg[0].err <= dv_reg[DV_STEPS-1].err;
        end
    end

    // binary search for the largest angle whose cosine is not below q
    for (genvar i = 0; i < SR_STEPS; i++)
    begin : g_search
        always_ff @(posedge clk)
        begin
            logic [8:0] sum;
            logic [7:0] mid;
            sr_st_t     sr_next;
            if (en)
            begin
                sum     = 9'(sr_reg[i].lo) + 9'(sr_reg[i].hi) + 9'd1;
                mid     = sum[8:1];
                sr_next = sr_reg[i];
                if (sr_reg[i].lo < sr_reg[i].hi)
                begin
                    if (sr_reg[i].q <= COS_TABLE[mid])
                    begin
                        sr_next.lo = mid;
                    end
                    else
                    begin
                        sr_next.hi = mid - 8'd1;
                    end
                end
                sr_reg[i+1] <= sr_next;
            end
        end
    end

    // drive the result
    assign angle_valid   = vld_reg[NST-1];
    assign angle_degrees = sr_reg[SR_STEPS].err ? 8'd0 : sr_reg[SR_STEPS].lo;
    assign status        = sr_reg[SR_STEPS].err ? STATUS_ZERO_LEN : STATUS_OK;

    // root remainder stays within the next square
    a_sqrt_rem : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ_END] |-> sq_reg[SQ_STEPS].rem <= {sq_reg[SQ_STEPS].root[62:0], 1'b0})
        else $error("square root remainder out of range");

    // normalized cosine never exceeds unity for a valid vector pair
    a_cos_range : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DV_END] && !dv_reg[DV_STEPS-1].err) |->
        dv_reg[DV_STEPS-1].quo <= 31'(ONE_Q30))
        else $error("cosine magnitude above one");

    // search window closes inside the angle range
    a_search_done : assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (sr_reg[SR_STEPS].lo == sr_reg[SR_STEPS].hi) &&
        (sr_reg[SR_STEPS].lo <= 8'(ANGLE_MAX)))
        else $error("angle search did not converge");

    // an error result reports angle zero
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && status == STATUS_ZERO_LEN) |-> angle_degrees == 8'd0)
        else $error("zero-length result with nonzero angle");

endmodule
